### design/ipsc_pkg.sv
// shared constants, types and helpers of the pixel statistics checker
`default_nettype none

package ipsc_pkg;

   localparam int COUNT_BITS     = 32;
   localparam int FRACTION_BITS  = 8;
   localparam int PIXEL_BITS     = 32;
   localparam int VALUE_BITS     = 32;
   localparam int SUM_BITS       = 64;
   localparam int LIMIT_BITS     = 17;
   localparam int RATIO_SHIFT    = 16;
   localparam int TYPE_BITS      = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int OUT_COUNT_BITS = 32;
   localparam int VERDICT_BITS   = 2;

   localparam logic [TYPE_BITS-1:0] TYPE_U8  = 2'd0;
   localparam logic [TYPE_BITS-1:0] TYPE_U16 = 2'd1;
   localparam logic [TYPE_BITS-1:0] TYPE_F32 = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ELEMENT_TYPE    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NONFINITE_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLACK_LIMIT     = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SATURATED_LIMIT = 2'd3;

   localparam logic [VERDICT_BITS-1:0] VERDICT_OK        = 2'd0;
   localparam logic [VERDICT_BITS-1:0] VERDICT_NONFINITE = 2'd1;
   localparam logic [VERDICT_BITS-1:0] VERDICT_BLACK     = 2'd2;
   localparam logic [VERDICT_BITS-1:0] VERDICT_SATURATED = 2'd3;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET  = 17'h10000;
   localparam logic [7:0]            U8_SAT       = 8'hFF;
   localparam logic [15:0]           U16_SAT      = 16'hFFFF;
   localparam logic [PIXEL_BITS-1:0] F32_SAT_BITS = 32'h437F0000;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic                         finite;
      logic                         black;
      logic                         saturated;
   } ipsc_pixel_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]        checked;
      logic [COUNT_BITS-1:0]        black;
      logic [COUNT_BITS-1:0]        saturated;
      logic [COUNT_BITS-1:0]        nonfinite;
      logic signed [VALUE_BITS-1:0] group_min;
      logic signed [VALUE_BITS-1:0] group_max;
      logic signed [SUM_BITS-1:0]   sum;
      logic signed [VALUE_BITS-1:0] mean;
   } ipsc_stats_type;

   typedef struct packed {
      logic                         done;
      logic [VERDICT_BITS-1:0]      verdict;
      logic signed [VALUE_BITS-1:0] mean;
   } ipsc_result_type;

   function automatic logic signed [VALUE_BITS-1:0] clamp_signed(input logic neg,
                                                                 input logic [SUM_BITS-1:0] mag);
      logic [SUM_BITS-1:0] pos_lim;
      logic [SUM_BITS-1:0] neg_lim;
      logic [SUM_BITS-1:0] m;
      pos_lim = SUM_BITS'({1'b0, {(VALUE_BITS-1){1'b1}}});
      neg_lim = SUM_BITS'(1) << (VALUE_BITS-1);
      if (neg) begin
         m = (mag > neg_lim) ? neg_lim : mag;
         m = ~m + 1'b1;
      end else begin
         m = (mag > pos_lim) ? pos_lim : mag;
      end
      return m[VALUE_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

### design/ipsc_convert.sv
// pixel decode: fixed point value and black, saturated and finite flags
`default_nettype none

module ipsc_convert
   import ipsc_pkg::*;
(
   input  logic [TYPE_BITS-1:0]  element_type,
   input  logic [PIXEL_BITS-1:0] pixel_bits,
   output ipsc_pixel_type        pixel
);

   localparam int F_BIAS_TOTAL = 150;
   localparam int F_SHIFT_CAP  = 40;
   localparam logic signed [10:0] F_SHIFT_BIAS = 11'(FRACTION_BITS - F_BIAS_TOTAL);
   localparam logic signed [10:0] F_SHIFT_MAX  = 11'(F_SHIFT_CAP);
   localparam logic signed [10:0] F_SHIFT_OUT  = 11'(SUM_BITS);

   logic [7:0]          f_exp;
   logic [7:0]          f_eexp;
   logic [23:0]         f_man;
   logic signed [10:0]  f_shift;
   logic signed [10:0]  f_nshift;
   logic [SUM_BITS-1:0] f_mag;

   always_comb begin
      f_exp    = pixel_bits[30:23];
      f_eexp   = (f_exp == 8'd0) ? 8'd1 : f_exp;
      f_man    = {(f_exp != 8'd0), pixel_bits[22:0]};
      f_shift  = $signed({3'b000, f_eexp}) + F_SHIFT_BIAS;
      f_nshift = -f_shift;
      if (f_shift > F_SHIFT_MAX) begin
         f_mag = SUM_BITS'(1) << (SUM_BITS-2);
      end else if (f_shift >= 11'sd0) begin
         f_mag = SUM_BITS'(f_man) << f_shift[5:0];
      end else if (f_nshift >= F_SHIFT_OUT) begin
         f_mag = '0;
      end else begin
         f_mag = SUM_BITS'(f_man) >> f_nshift[5:0];
      end
   end

   always_comb begin
      pixel.value     = '0;
      pixel.finite    = 1'b1;
      pixel.black     = 1'b0;
      pixel.saturated = 1'b0;
      unique case (element_type)
         TYPE_U8: begin
            pixel.value     = clamp_signed(1'b0, SUM_BITS'(pixel_bits[7:0]) << FRACTION_BITS);
            pixel.black     = (pixel_bits[7:0] == 8'd0);
            pixel.saturated = (pixel_bits[7:0] == U8_SAT);
         end
         TYPE_U16: begin
            pixel.value     = clamp_signed(1'b0, SUM_BITS'(pixel_bits[15:0]) << FRACTION_BITS);
            pixel.black     = (pixel_bits[15:0] == 16'd0);
            pixel.saturated = (pixel_bits[15:0] == U16_SAT);
         end
         TYPE_F32: begin
            if (f_exp == 8'hFF) begin
               pixel.finite = 1'b0;
            end else begin
               pixel.value     = clamp_signed(pixel_bits[31], f_mag);
               pixel.black     = (pixel_bits[30:0] == 31'd0);
               pixel.saturated = !pixel_bits[31] && (pixel_bits >= F32_SAT_BITS);
            end
         end
         default: begin
            pixel.finite = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

### design/ipsc_stats.sv
// group statistics registers: saturating counts, extremes, sum and mean
`default_nettype none

module ipsc_stats
   import ipsc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic            first_in_group,
   input  ipsc_pixel_type  pixel,
   input  ipsc_result_type result,
   output ipsc_stats_type  stats
);

   logic [COUNT_BITS-1:0]        checked_ff, checked_in;
   logic [COUNT_BITS-1:0]        black_ff, black_in;
   logic [COUNT_BITS-1:0]        saturated_ff, saturated_in;
   logic [COUNT_BITS-1:0]        nonfinite_ff, nonfinite_in;
   logic signed [VALUE_BITS-1:0] min_ff, min_in;
   logic signed [VALUE_BITS-1:0] max_ff, max_in;
   logic signed [SUM_BITS-1:0]   sum_ff, sum_in;
   logic                         valid_ff, valid_in;
   logic signed [VALUE_BITS-1:0] mean_ff, mean_in;

   logic [COUNT_BITS-1:0]        b_checked, b_black, b_saturated, b_nonfinite;
   logic signed [VALUE_BITS-1:0] b_min, b_max, b_mean;
   logic signed [SUM_BITS-1:0]   b_sum;
   logic                         b_valid;
   logic signed [VALUE_BITS-1:0] pix_value;
   logic [SUM_BITS-1:0]          sum_ext;
   logic [SUM_BITS-1:0]          sum_raw;
   logic                         sum_ovf;
   logic signed [SUM_BITS-1:0]   sum_sat;

   function automatic logic [COUNT_BITS-1:0] inc_sat(input logic [COUNT_BITS-1:0] c);
      return (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
   endfunction

   assign pix_value = pixel.value;

   always_comb begin
      b_checked   = first_in_group ? '0 : checked_ff;
      b_black     = first_in_group ? '0 : black_ff;
      b_saturated = first_in_group ? '0 : saturated_ff;
      b_nonfinite = first_in_group ? '0 : nonfinite_ff;
      b_min       = first_in_group ? '0 : min_ff;
      b_max       = first_in_group ? '0 : max_ff;
      b_sum       = first_in_group ? '0 : sum_ff;
      b_valid     = first_in_group ? 1'b0 : valid_ff;
      b_mean      = first_in_group ? '0 : mean_ff;
   end

   // saturating signed add of the new value
   always_comb begin
      sum_ext = {{(SUM_BITS-VALUE_BITS){pix_value[VALUE_BITS-1]}}, pix_value};
      sum_raw = b_sum + sum_ext;
      sum_ovf = (b_sum[SUM_BITS-1] == sum_ext[SUM_BITS-1]) &&
                (sum_raw[SUM_BITS-1] != b_sum[SUM_BITS-1]);
      if (sum_ovf) begin
         sum_sat = b_sum[SUM_BITS-1] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                     : {1'b0, {(SUM_BITS-1){1'b1}}};
      end else begin
         sum_sat = sum_raw;
      end
   end

   always_comb begin
      checked_in   = checked_ff;
      black_in     = black_ff;
      saturated_in = saturated_ff;
      nonfinite_in = nonfinite_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      sum_in       = sum_ff;
      valid_in     = valid_ff;
      mean_in      = mean_ff;
      if (accept) begin
         checked_in   = inc_sat(b_checked);
         black_in     = b_black;
         saturated_in = b_saturated;
         nonfinite_in = b_nonfinite;
         min_in       = b_min;
         max_in       = b_max;
         sum_in       = b_sum;
         valid_in     = b_valid;
         mean_in      = b_mean;
         if (!pixel.finite) begin
            nonfinite_in = inc_sat(b_nonfinite);
         end else begin
            if (pixel.black) begin
               black_in = inc_sat(b_black);
            end
            if (pixel.saturated) begin
               saturated_in = inc_sat(b_saturated);
            end
            sum_in = sum_sat;
            if (!b_valid) begin
               min_in   = pix_value;
               max_in   = pix_value;
               valid_in = 1'b1;
            end else begin
               if (pix_value < b_min) begin
                  min_in = pix_value;
               end
               if (pix_value > b_max) begin
                  max_in = pix_value;
               end
            end
         end
      end else if (result.done) begin
         mean_in = result.mean;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         checked_ff   <= '0;
         black_ff     <= '0;
         saturated_ff <= '0;
         nonfinite_ff <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         sum_ff       <= '0;
         valid_ff     <= 1'b0;
         mean_ff      <= '0;
      end else begin
         checked_ff   <= checked_in;
         black_ff     <= black_in;
         saturated_ff <= saturated_in;
         nonfinite_ff <= nonfinite_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         valid_ff     <= valid_in;
         mean_ff      <= mean_in;
      end
   end

   assign stats.checked   = checked_ff;
   assign stats.black     = black_ff;
   assign stats.saturated = saturated_ff;
   assign stats.nonfinite = nonfinite_ff;
   assign stats.group_min = min_ff;
   assign stats.group_max = max_ff;
   assign stats.sum       = sum_ff;
   assign stats.mean      = mean_ff;

endmodule

`default_nettype wire

### design/ipsc_seq.sv
// end-of-image sequencer: shared add/subtract unit for mean divide and ratio checks
`default_nettype none

module ipsc_seq
   import ipsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  out_free,
   input  ipsc_stats_type        stats,
   input  logic [LIMIT_BITS-1:0] nonfinite_limit,
   input  logic [LIMIT_BITS-1:0] black_limit,
   input  logic [LIMIT_BITS-1:0] saturated_limit,
   output logic                  idle,
   output ipsc_result_type       result
);

   localparam int UNIT_BITS      = COUNT_BITS + LIMIT_BITS;
   localparam int ITER_BITS      = $clog2(SUM_BITS > LIMIT_BITS ? SUM_BITS : LIMIT_BITS);
   localparam int LIMIT_IDX_BITS = $clog2(LIMIT_BITS);

   localparam logic [1:0] CHECK_NONFINITE = 2'd0;
   localparam logic [1:0] CHECK_BLACK     = 2'd1;
   localparam logic [1:0] CHECK_SATURATED = 2'd2;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_LOAD = 7'b0000010,
      S_DIV  = 7'b0000100,
      S_MEAN = 7'b0001000,
      S_MUL  = 7'b0010000,
      S_CMP  = 7'b0100000,
      S_DONE = 7'b1000000
   } ipsc_state_type;

   ipsc_state_type               state_ff, state_in;
   logic [ITER_BITS-1:0]         iter_ff, iter_in;
   logic [1:0]                   check_ff, check_in;
   logic [COUNT_BITS-1:0]        rem_ff, rem_in;
   logic [SUM_BITS-1:0]          quo_ff, quo_in;
   logic [COUNT_BITS-1:0]        fcount_ff, fcount_in;
   logic                         neg_ff, neg_in;
   logic [UNIT_BITS-1:0]         acc_ff, acc_in;
   logic [VERDICT_BITS-1:0]      verdict_ff, verdict_in;
   logic signed [VALUE_BITS-1:0] mean_ff, mean_in;
   logic                         result_done;

   logic [UNIT_BITS-1:0]  unit_a;
   logic [UNIT_BITS-1:0]  unit_b;
   logic                  unit_sub;
   logic [UNIT_BITS:0]    unit_res;
   logic                  unit_neg;
   logic                  unit_zero;

   logic [COUNT_BITS:0]   div_trial;
   logic [COUNT_BITS-1:0] sel_count;
   logic [LIMIT_BITS-1:0] sel_limit;
   logic [VERDICT_BITS-1:0] sel_verdict;
   logic                  cmp_fail;
   logic [COUNT_BITS-1:0] ld_fcount;
   logic [SUM_BITS-1:0]   ld_mag;

   always_comb begin
      unique case (check_ff)
         CHECK_NONFINITE: begin
            sel_count   = stats.nonfinite;
            sel_limit   = nonfinite_limit;
            sel_verdict = VERDICT_NONFINITE;
         end
         CHECK_BLACK: begin
            sel_count   = stats.black;
            sel_limit   = black_limit;
            sel_verdict = VERDICT_BLACK;
         end
         default: begin
            sel_count   = stats.saturated;
            sel_limit   = saturated_limit;
            sel_verdict = VERDICT_SATURATED;
         end
      endcase
   end

   assign div_trial = {rem_ff, quo_ff[SUM_BITS-1]};
   assign ld_fcount = (stats.checked > stats.nonfinite) ? stats.checked - stats.nonfinite : '0;
   assign ld_mag    = stats.sum[SUM_BITS-1] ? (~stats.sum + 1'b1) : stats.sum;

   // shared unit operand selection
   always_comb begin
      unit_a   = '0;
      unit_b   = '0;
      unit_sub = 1'b0;
      unique case (state_ff)
         S_DIV: begin
            unit_a   = UNIT_BITS'(div_trial);
            unit_b   = UNIT_BITS'(fcount_ff);
            unit_sub = 1'b1;
         end
         S_MUL: begin
            unit_a = {acc_ff[UNIT_BITS-2:0], 1'b0};
            unit_b = sel_limit[iter_ff[LIMIT_IDX_BITS-1:0]] ? UNIT_BITS'(stats.checked) : '0;
         end
         S_CMP: begin
            unit_a   = UNIT_BITS'({sel_count, {RATIO_SHIFT{1'b0}}});
            unit_b   = acc_ff;
            unit_sub = 1'b1;
         end
         default: begin
            unit_sub = 1'b0;
         end
      endcase
   end

   assign unit_res  = {1'b0, unit_a} + ({1'b0, unit_b} ^ {(UNIT_BITS+1){unit_sub}})
                      + (UNIT_BITS+1)'(unit_sub);
   assign unit_neg  = unit_res[UNIT_BITS];
   assign unit_zero = (unit_res[UNIT_BITS-1:0] == '0);

   // non-finite fails only when strictly above the limit
   assign cmp_fail = (check_ff == CHECK_NONFINITE) ? (!unit_neg && !unit_zero) : !unit_neg;

   always_comb begin
      state_in    = state_ff;
      iter_in     = iter_ff;
      check_in    = check_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      fcount_in   = fcount_ff;
      neg_in      = neg_ff;
      acc_in      = acc_ff;
      verdict_in  = verdict_ff;
      mean_in     = mean_ff;
      result_done = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            mean_in   = stats.mean;
            check_in  = CHECK_NONFINITE;
            acc_in    = '0;
            fcount_in = ld_fcount;
            neg_in    = stats.sum[SUM_BITS-1];
            quo_in    = ld_mag;
            rem_in    = '0;
            if (ld_fcount != '0) begin
               iter_in  = ITER_BITS'(SUM_BITS-1);
               state_in = S_DIV;
            end else begin
               iter_in  = ITER_BITS'(LIMIT_BITS-1);
               state_in = S_MUL;
            end
         end
         S_DIV: begin
            rem_in  = unit_neg ? div_trial[COUNT_BITS-1:0] : unit_res[COUNT_BITS-1:0];
            quo_in  = {quo_ff[SUM_BITS-2:0], !unit_neg};
            iter_in = iter_ff - 1'b1;
            if (iter_ff == '0) begin
               state_in = S_MEAN;
            end
         end
         S_MEAN: begin
            mean_in  = clamp_signed(neg_ff, quo_ff);
            acc_in   = '0;
            iter_in  = ITER_BITS'(LIMIT_BITS-1);
            state_in = S_MUL;
         end
         S_MUL: begin
            acc_in  = unit_res[UNIT_BITS-1:0];
            iter_in = iter_ff - 1'b1;
            if (iter_ff == '0) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (cmp_fail) begin
               verdict_in = sel_verdict;
               state_in   = S_DONE;
            end else if (check_ff == CHECK_SATURATED) begin
               verdict_in = VERDICT_OK;
               state_in   = S_DONE;
            end else begin
               check_in = check_ff + 1'b1;
               acc_in   = '0;
               iter_in  = ITER_BITS'(LIMIT_BITS-1);
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            if (out_free) begin
               result_done = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iter_ff  <= '0;
         check_ff <= CHECK_NONFINITE;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         check_ff <= check_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      fcount_ff  <= fcount_in;
      neg_ff     <= neg_in;
      acc_ff     <= acc_in;
      verdict_ff <= verdict_in;
      mean_ff    <= mean_in;
   end

   assign idle           = (state_ff == S_IDLE);
   assign result.done    = result_done;
   assign result.verdict = verdict_ff;
   assign result.mean    = mean_ff;

endmodule

`default_nettype wire

### design/image_pixel_statistics_checker.sv
// top level of the pixel statistics checker: config registers, handshakes, response register
//
//   channel | direction | accepted when           | carries
//   req     | in        | req_valid & req_ready   | pixel bits, last/first marks
//   rsp     | out       | rsp_valid & rsp_ready   | verdict, min, max, mean, totals
//   csr     | in        | csr_we                  | register index and data
//
// a request without last_in_image keeps the sequencer idle; the next one is taken right after
// a last request runs the shared unit: a load, 64 divide steps and a mean step if any finite
// element exists, one to three ratio checks, a hand-over once the response register is free
// the response register holds a result while the next requests are already taken
// reset is synchronous and returns config registers to their defaults and clears the group
`default_nettype none

module image_pixel_statistics_checker
   import ipsc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [PIXEL_BITS-1:0]        req_pixel_bits,
   input  logic                         req_last_in_image,
   input  logic                         req_first_in_group,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [VERDICT_BITS-1:0]      rsp_verdict,
   output logic signed [VALUE_BITS-1:0] rsp_group_min,
   output logic signed [VALUE_BITS-1:0] rsp_group_max,
   output logic signed [VALUE_BITS-1:0] rsp_group_mean,
   output logic [OUT_COUNT_BITS-1:0]    rsp_checked_total,
   output logic [OUT_COUNT_BITS-1:0]    rsp_black_total,
   output logic [OUT_COUNT_BITS-1:0]    rsp_saturated_total,
   output logic [OUT_COUNT_BITS-1:0]    rsp_nonfinite_total,
   input  logic                         csr_we,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [LIMIT_BITS-1:0]        csr_wdata
);

   logic [TYPE_BITS-1:0]  element_type_ff;
   logic [LIMIT_BITS-1:0] nonfinite_limit_ff;
   logic [LIMIT_BITS-1:0] black_limit_ff;
   logic [LIMIT_BITS-1:0] saturated_limit_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_BITS-1:0]      verdict_ff;
   logic signed [VALUE_BITS-1:0] min_ff, max_ff, mean_ff;
   logic [OUT_COUNT_BITS-1:0]    checked_ff, black_ff, saturated_ff, nonfinite_ff;

   logic            req_accept;
   logic            seq_idle;
   logic            out_free;
   ipsc_pixel_type  pixel;
   ipsc_stats_type  stats;
   ipsc_result_type result;

   function automatic logic [OUT_COUNT_BITS-1:0] out_count(input logic [COUNT_BITS-1:0] c);
      logic [SUM_BITS-1:0] w;
      w = SUM_BITS'(c);
      return (w > SUM_BITS'({OUT_COUNT_BITS{1'b1}})) ? {OUT_COUNT_BITS{1'b1}}
                                                     : w[OUT_COUNT_BITS-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         element_type_ff    <= TYPE_U8;
         nonfinite_limit_ff <= LIMIT_RESET;
         black_limit_ff     <= LIMIT_RESET;
         saturated_limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ELEMENT_TYPE:    element_type_ff    <= csr_wdata[TYPE_BITS-1:0];
            CSR_NONFINITE_LIMIT: nonfinite_limit_ff <= csr_wdata;
            CSR_BLACK_LIMIT:     black_limit_ff     <= csr_wdata;
            CSR_SATURATED_LIMIT: saturated_limit_ff <= csr_wdata;
         endcase
      end
   end

   assign req_ready  = seq_idle;
   assign req_accept = req_valid && seq_idle;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   ipsc_convert u_convert (
      .element_type (element_type_ff),
      .pixel_bits   (req_pixel_bits),
      .pixel        (pixel)
   );

   ipsc_stats u_stats (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .first_in_group (req_first_in_group),
      .pixel          (pixel),
      .result         (result),
      .stats          (stats)
   );

   ipsc_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .start           (req_accept && req_last_in_image),
      .out_free        (out_free),
      .stats           (stats),
      .nonfinite_limit (nonfinite_limit_ff),
      .black_limit     (black_limit_ff),
      .saturated_limit (saturated_limit_ff),
      .idle            (seq_idle),
      .result          (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.done) begin
         verdict_ff   <= result.verdict;
         min_ff       <= stats.group_min;
         max_ff       <= stats.group_max;
         mean_ff      <= result.mean;
         checked_ff   <= out_count(stats.checked);
         black_ff     <= out_count(stats.black);
         saturated_ff <= out_count(stats.saturated);
         nonfinite_ff <= out_count(stats.nonfinite);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_verdict         = verdict_ff;
   assign rsp_group_min       = min_ff;
   assign rsp_group_max       = max_ff;
   assign rsp_group_mean      = mean_ff;
   assign rsp_checked_total   = checked_ff;
   assign rsp_black_total     = black_ff;
   assign rsp_saturated_total = saturated_ff;
   assign rsp_nonfinite_total = nonfinite_ff;

endmodule

`default_nettype wire
